>>> rtl/nlfc_pkg.sv
package nlfc_pkg;

    // Default build values for the top-level parameters
    localparam int ADC_WIDTH_DEF    = 10;
    localparam int FADE_STEP_MS_DEF = 16;

    // Width of the 10-bit ADC field and of the threshold compares
    localparam int ADC_FIELD_W = 10;

    // Configuration port sizing
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NIGHT_BRIGHT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMERGENCY_BRIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT         = 3'd4;

    // Light mode codes
    localparam logic [2:0] MODE_EMERGENCY = 3'd0;
    localparam logic [2:0] MODE_NIGHT     = 3'd1;
    localparam logic [2:0] MODE_BOTH      = 3'd2;

    // Supply thresholds for 10-bit and 8-bit converters
    localparam logic [ADC_FIELD_W-1:0] SUPPLY_LOW_10  = 10'd127;
    localparam logic [ADC_FIELD_W-1:0] SUPPLY_HIGH_10 = 10'd191;
    localparam logic [ADC_FIELD_W-1:0] SUPPLY_LOW_8   = 10'd31;
    localparam logic [ADC_FIELD_W-1:0] SUPPLY_HIGH_8  = 10'd47;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_EMG   = 3'd1,
        PH_FDI   = 3'd2,
        PH_NIGHT = 3'd3,
        PH_FDO   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [2:0] light_mode;
        logic [1:0] light_threshold_index;
        logic [2:0] night_bright_index;
        logic [2:0] emergency_bright_index;
        logic [1:0] timeout_index;
    } cfg_t;

    // Brightness table, index saturates at the last entry
    function automatic logic [7:0] bright_level(input logic [2:0] idx);
        logic [7:0] lvl;
        case (idx)
            3'd0:    lvl = 8'd31;
            3'd1:    lvl = 8'd63;
            3'd2:    lvl = 8'd127;
            3'd3:    lvl = 8'd191;
            default: lvl = 8'd255;
        endcase
        return lvl;
    endfunction

    // Darkness threshold in ADC counts
    function automatic logic [ADC_FIELD_W-1:0] dark_threshold(input logic [1:0] idx,
                                                             input logic eight);
        logic [ADC_FIELD_W-1:0] th;
        case (idx)
            2'd0:    th = eight ? 10'd1 : 10'd4;
            2'd1:    th = eight ? 10'd4 : 10'd16;
            default: th = eight ? 10'd40 : 10'd160;
        endcase
        return th;
    endfunction

    // Night hold time in ms: hold units less fade units, 256 ms per unit
    function automatic logic [15:0] hold_limit(input logic [1:0] tidx,
                                               input logic [2:0] bidx);
        logic [7:0] h;
        logic [7:0] f;
        logic [7:0] d;
        case (tidx)
            2'd0:    h = 8'h3B;
            2'd1:    h = 8'h76;
            default: h = 8'hEB;
        endcase
        case (bidx)
            3'd0:    f = 8'd2;
            3'd1:    f = 8'd4;
            3'd2:    f = 8'd8;
            3'd3:    f = 8'd12;
            default: f = 8'd16;
        endcase
        d = h - f;
        return {d, 8'h00};
    endfunction

endpackage

>>> rtl/nlfc_cfg_regs.sv
module nlfc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nlfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nlfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output nlfc_pkg::cfg_t                   cfg
);

    nlfc_pkg::cfg_t cfg_reg;

    // Always take a write request
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Store the addressed register, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_mode             <= nlfc_pkg::MODE_BOTH;
            cfg_reg.light_threshold_index  <= 2'd0;
            cfg_reg.night_bright_index     <= 3'd0;
            cfg_reg.emergency_bright_index <= 3'd0;
            cfg_reg.timeout_index          <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nlfc_pkg::CFG_LIGHT_MODE:       cfg_reg.light_mode <= cfg_data[2:0];
                nlfc_pkg::CFG_LIGHT_THRESHOLD:  cfg_reg.light_threshold_index <= cfg_data[1:0];
                nlfc_pkg::CFG_NIGHT_BRIGHT:     cfg_reg.night_bright_index <= cfg_data[2:0];
                nlfc_pkg::CFG_EMERGENCY_BRIGHT: cfg_reg.emergency_bright_index <= cfg_data[2:0];
                nlfc_pkg::CFG_TIMEOUT:          cfg_reg.timeout_index <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/nlfc_step.sv
module nlfc_step #(
    parameter int ADC_WIDTH    = nlfc_pkg::ADC_WIDTH_DEF,
    parameter int FADE_STEP_MS = nlfc_pkg::FADE_STEP_MS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  nlfc_pkg::cfg_t                   cfg,
    input  logic [31:0]                      now_ms,
    input  logic                             menu_off,
    input  logic                             conversion_done,
    input  logic [nlfc_pkg::ADC_FIELD_W-1:0] conversion_value,
    input  logic                             motion,
    output logic                             res_write,
    output logic [7:0]                       res_level,
    output logic [2:0]                       res_phase
);

    localparam logic EIGHT_BIT = (ADC_WIDTH == 8);
    localparam logic [nlfc_pkg::ADC_FIELD_W-1:0] SET_TH =
        EIGHT_BIT ? nlfc_pkg::SUPPLY_LOW_8 : nlfc_pkg::SUPPLY_LOW_10;
    localparam logic [nlfc_pkg::ADC_FIELD_W-1:0] CLR_TH =
        EIGHT_BIT ? nlfc_pkg::SUPPLY_HIGH_8 : nlfc_pkg::SUPPLY_HIGH_10;
    localparam logic [31:0] STEP_LIMIT = 32'(FADE_STEP_MS);

    nlfc_pkg::phase_t       phase_reg, phase_next;
    logic                   chan_reg;
    logic [ADC_WIDTH-1:0]   supply_reg, ambient_reg;
    logic [31:0]            mark_reg, mark_next;
    logic [7:0]             fade_reg, fade_next;

    logic [ADC_WIDTH-1:0]   sample;
    logic [ADC_WIDTH-1:0]   supply_eff, ambient_eff;
    logic                   supply_lost, supply_back, dark, emg_mode, night_mode;
    logic [31:0]            elapsed;
    logic                   step_due, hold_due;
    logic [7:0]             night_target;

    // Fold this pass's sample into the channel it belongs to
    assign sample      = conversion_value[ADC_WIDTH-1:0];
    assign supply_eff  = (conversion_done && !chan_reg) ? sample : supply_reg;
    assign ambient_eff = (conversion_done && chan_reg) ? sample : ambient_reg;

    // Derive power and light conditions
    assign supply_lost = nlfc_pkg::ADC_FIELD_W'(supply_eff) < SET_TH;
    assign supply_back = nlfc_pkg::ADC_FIELD_W'(supply_eff) > CLR_TH;
    assign dark       = nlfc_pkg::ADC_FIELD_W'(ambient_eff) <
                        nlfc_pkg::dark_threshold(cfg.light_threshold_index, EIGHT_BIT);
    assign emg_mode   = (cfg.light_mode == nlfc_pkg::MODE_EMERGENCY) ||
                        (cfg.light_mode == nlfc_pkg::MODE_BOTH);
    assign night_mode = (cfg.light_mode == nlfc_pkg::MODE_NIGHT) ||
                        (cfg.light_mode == nlfc_pkg::MODE_BOTH);

    // Timers
    assign elapsed      = now_ms - mark_reg;
    assign step_due     = elapsed > STEP_LIMIT;
    assign hold_due     = elapsed > {16'h0000,
                          nlfc_pkg::hold_limit(cfg.timeout_index, cfg.night_bright_index)};
    assign night_target = nlfc_pkg::bright_level(cfg.night_bright_index);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (menu_off)
        begin
            case (phase_reg)
                nlfc_pkg::PH_IDLE:
                begin
                    if (supply_lost && emg_mode)
                        phase_next = nlfc_pkg::PH_EMG;
                    else if (dark && motion && night_mode)
                        phase_next = nlfc_pkg::PH_FDI;
                end
                nlfc_pkg::PH_EMG:
                begin
                    if (supply_back)
                        phase_next = nlfc_pkg::PH_IDLE;
                end
                nlfc_pkg::PH_FDI:
                begin
                    if (step_due && fade_reg == night_target)
                        phase_next = nlfc_pkg::PH_NIGHT;
                end
                nlfc_pkg::PH_NIGHT:
                begin
                    if (!motion && hold_due)
                        phase_next = nlfc_pkg::PH_FDO;
                end
                nlfc_pkg::PH_FDO:
                begin
                    if (step_due)
                    begin
                        if (fade_reg == 8'd0)
                            phase_next = nlfc_pkg::PH_IDLE;
                        else if (motion)
                            phase_next = nlfc_pkg::PH_FDI;
                    end
                end
                default: phase_next = nlfc_pkg::PH_IDLE;
            endcase
        end
    end

    // LED write, timer mark and fade counter
    always_comb
    begin
        res_write = 1'b0;
        res_level = 8'd0;
        mark_next = mark_reg;
        fade_next = fade_reg;
        if (menu_off)
        begin
            case (phase_reg)
                nlfc_pkg::PH_IDLE:
                begin
                    if (supply_lost && emg_mode)
                    begin
                        res_write = 1'b1;
                        res_level = nlfc_pkg::bright_level(cfg.emergency_bright_index);
                    end
                    else if (dark && motion && night_mode)
                    begin
                        fade_next = 8'd0;
                        mark_next = now_ms;
                    end
                end
                nlfc_pkg::PH_EMG:
                begin
                    if (supply_back)
                        res_write = 1'b1;
                end
                nlfc_pkg::PH_FDI:
                begin
                    if (step_due)
                    begin
                        mark_next = now_ms;
                        if (fade_reg != night_target)
                        begin
                            res_write = 1'b1;
                            res_level = fade_reg;
                            fade_next = fade_reg + 8'd1;
                        end
                    end
                end
                nlfc_pkg::PH_NIGHT:
                begin
                    if (motion || hold_due)
                        mark_next = now_ms;
                end
                nlfc_pkg::PH_FDO:
                begin
                    if (step_due)
                    begin
                        mark_next = now_ms;
                        if (fade_reg != 8'd0 && !motion)
                        begin
                            res_write = 1'b1;
                            res_level = fade_reg;
                            fade_next = fade_reg - 8'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign res_phase = phase_next;

    // Commit the pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= nlfc_pkg::PH_IDLE;
            chan_reg    <= 1'b0;
            supply_reg  <= '0;
            ambient_reg <= '1;
            mark_reg    <= 32'd0;
            fade_reg    <= 8'd0;
        end
        else if (advance && menu_off)
        begin
            phase_reg <= phase_next;
            mark_reg  <= mark_next;
            fade_reg  <= fade_next;
            if (conversion_done)
            begin
                chan_reg    <= !chan_reg;
                supply_reg  <= supply_eff;
                ambient_reg <= ambient_eff;
            end
        end
    end

endmodule

>>> rtl/night_light_fade_controller_core.sv
// Night light fade controller.
// Input channel (in_valid/in_ready) takes one request per main-loop pass:
// now_ms, menu_off, conversion_done, conversion_value and motion. The
// output channel (out_valid/out_ready) returns exactly one result per
// request: led_write, led_level (0 unless written) and phase.
// Configuration writes use cfg_valid/cfg_ready with cfg_index 0..4
// (light_mode, light_threshold_index, night_bright_index,
// emergency_bright_index, timeout_index); cfg_ready is always high and
// indexes past the list are dropped. Write only while the block is idle.
// A request passes through one input register, then the phase update and
// the result register. Throughput is one request per cycle while the
// receiver takes results, set by the phase update loop.
// When the receiver stalls, the result register holds, the input register
// fills next, and in_ready drops only when both are full.
// Reset clears both stages, sets phase idle, supply sample zero, ambient
// sample full scale, and loads the configuration defaults.
module night_light_fade_controller_core #(
    parameter int ADC_WIDTH    = nlfc_pkg::ADC_WIDTH_DEF,
    parameter int FADE_STEP_MS = nlfc_pkg::FADE_STEP_MS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [31:0]                      now_ms,
    input  logic                             menu_off,
    input  logic                             conversion_done,
    input  logic [nlfc_pkg::ADC_FIELD_W-1:0] conversion_value,
    input  logic                             motion,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             led_write,
    output logic [7:0]                       led_level,
    output logic [2:0]                       phase,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nlfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nlfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    nlfc_pkg::cfg_t cfg;

    logic                             s1_valid_reg;
    logic [31:0]                      s1_now_reg;
    logic                             s1_menu_reg;
    logic                             s1_done_reg;
    logic [nlfc_pkg::ADC_FIELD_W-1:0] s1_value_reg;
    logic                             s1_motion_reg;

    logic                             out_valid_reg;
    logic                             out_write_reg;
    logic [7:0]                       out_level_reg;
    logic [2:0]                       out_phase_reg;

    logic                             advance;
    logic                             res_write;
    logic [7:0]                       res_level;
    logic [2:0]                       res_phase;

    nlfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nlfc_step #(
        .ADC_WIDTH    (ADC_WIDTH),
        .FADE_STEP_MS (FADE_STEP_MS)
    ) u_step (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .cfg              (cfg),
        .now_ms           (s1_now_reg),
        .menu_off         (s1_menu_reg),
        .conversion_done  (s1_done_reg),
        .conversion_value (s1_value_reg),
        .motion           (s1_motion_reg),
        .res_write        (res_write),
        .res_level        (res_level),
        .res_phase        (res_phase)
    );

    // Advance the held request when the result slot is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_now_reg    <= now_ms;
            s1_menu_reg   <= menu_off;
            s1_done_reg   <= conversion_done;
            s1_value_reg  <= conversion_value;
            s1_motion_reg <= motion;
        end
    end

    // Result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_write_reg <= res_write;
            out_level_reg <= res_level;
            out_phase_reg <= res_phase;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_write = out_write_reg;
    assign led_level = out_level_reg;
    assign phase     = out_phase_reg;

endmodule
